// File: rtl/lpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the lamp PWM pattern controller.
// No dependencies; imported by every module of the block.
package lpc_pkg;

	localparam int MODE_W   = 3;
	localparam int PERIOD_W = 20;
	localparam int GAP_W    = 16;
	localparam int HALF_W   = 24;
	localparam int DIV_W    = 14;
	localparam int LEVEL_W  = 7;
	localparam int COUNT_W  = 8;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	// lamp modes
	localparam logic [MODE_W-1:0] MODE_OFF  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SAW  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FAST = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TRI  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SLOW = 3'd4;

	// register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_PERIOD = 3'd1,
		REG_GAP    = 3'd2,
		REG_FAST   = 3'd3,
		REG_SLOW   = 3'd4
	} lpc_reg_e;

	// PWM phases
	localparam logic [1:0] PH_ON  = 2'd0;
	localparam logic [1:0] PH_OFF = 2'd1;
	localparam logic [1:0] PH_GAP = 2'd2;

	// reset values
	localparam logic [MODE_W-1:0]   RST_MODE   = MODE_OFF;
	localparam logic [PERIOD_W-1:0] RST_PERIOD = 20'd20000;
	localparam logic [GAP_W-1:0]    RST_GAP    = 16'd1000;
	localparam logic [HALF_W-1:0]   RST_FAST   = 24'd166000;
	localparam logic [HALF_W-1:0]   RST_SLOW   = 24'd1000000;
	localparam logic [DIV_W-1:0]    RST_DIV    = 14'd200;

	// x / 100 as (x * ceil(2^27/100)) >> 27, exact for x below 2^20
	localparam int                 DIV100_SHIFT = 27;
	localparam logic [20:0]        DIV100_MUL   = 21'd1342178;
	localparam int                 PROD_W       = PERIOD_W + 21;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;
	localparam logic [COUNT_W:0]   SAW_WRAP   = 9'd100;
	localparam logic [COUNT_W:0]   TRI_WRAP   = 9'd200;

	typedef struct packed {
		logic                mode_wr;
		logic [MODE_W-1:0]   mode;
		logic [PERIOD_W-1:0] period;
		logic [DIV_W-1:0]    period_div;
		logic [GAP_W-1:0]    gap;
		logic [HALF_W-1:0]   fast_half;
		logic [HALF_W-1:0]   slow_half;
	} lpc_cfg_t;

	typedef struct packed {
		logic               lamp_on;
		logic               fan_out;
		logic [LEVEL_W-1:0] level;
	} lpc_word_t;

endpackage

// File: rtl/lpc_regs.sv
`timescale 1ns / 1ps
// APB register file for the lamp PWM pattern controller.
// Depends on lpc_pkg; also precomputes pwm_period / 100 at write time.
module lpc_regs import lpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	output lpc_cfg_t            cfg
);

	logic [MODE_W-1:0]   mode_q;
	logic [PERIOD_W-1:0] period_q;
	logic [DIV_W-1:0]    period_div_q;
	logic [GAP_W-1:0]    gap_q;
	logic [HALF_W-1:0]   fast_q;
	logic [HALF_W-1:0]   slow_q;
	logic                wr;
	logic [2:0]          idx;
	logic [PROD_W-1:0]   div_prod;

	assign pready   = 1'b1;
	assign wr       = psel & penable & pwrite;
	assign idx      = paddr[4:2];
	assign div_prod = PROD_W'(pwdata[PERIOD_W-1:0]) * PROD_W'(DIV100_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= RST_MODE;
			period_q     <= RST_PERIOD;
			period_div_q <= RST_DIV;
			gap_q        <= RST_GAP;
			fast_q       <= RST_FAST;
			slow_q       <= RST_SLOW;
		end else if (wr) begin
			case (idx)
				REG_MODE: begin
					mode_q <= pwdata[MODE_W-1:0];
				end
				REG_PERIOD: begin
					period_q     <= pwdata[PERIOD_W-1:0];
					period_div_q <= div_prod[DIV100_SHIFT +: DIV_W];
				end
				REG_GAP: begin
					gap_q <= pwdata[GAP_W-1:0];
				end
				REG_FAST: begin
					fast_q <= pwdata[HALF_W-1:0];
				end
				REG_SLOW: begin
					slow_q <= pwdata[HALF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:   prdata = DATA_W'(mode_q);
			REG_PERIOD: prdata = DATA_W'(period_q);
			REG_GAP:    prdata = DATA_W'(gap_q);
			REG_FAST:   prdata = DATA_W'(fast_q);
			REG_SLOW:   prdata = DATA_W'(slow_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		cfg.mode_wr    = wr && (idx == REG_MODE);
		cfg.mode       = mode_q;
		cfg.period     = period_q;
		cfg.period_div = period_div_q;
		cfg.gap        = gap_q;
		cfg.fast_half  = fast_q;
		cfg.slow_half  = slow_q;
	end

endmodule

// File: rtl/lamp_pwm_pattern_controller.sv
`timescale 1ns / 1ps
// Lamp PWM pattern controller: one word in per microsecond tick, one word out.
// Output: an accepted word is registered in the output buffer, or its skid entry.
// Throughput: one word per cycle unless stalled; a two-entry output buffer keeps in_ready high
// while a single result waits. Counter update is one short compare/add path.
// Reset: arst_n clears counters and output buffer and loads register defaults.
module lamp_pwm_pattern_controller import lpc_pkg::*; #(
	parameter int TIMER_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               fan_on,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               lamp_on,
	output logic               fan_out,
	output logic [LEVEL_W-1:0] level,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam int TW = TIMER_BITS;
	localparam int CW = (TIMER_BITS > HALF_W) ? TIMER_BITS : HALF_W;

	lpc_cfg_t cfg;

	lpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [TW-1:0]      timer_q;
	logic [COUNT_W-1:0] pcount_q;
	logic [LEVEL_W-1:0] intensity_q;
	logic [1:0]         phase_q;

	logic [TW-1:0]       timer_d;
	logic [COUNT_W-1:0]  pcount_d;
	logic [LEVEL_W-1:0]  intensity_d;
	logic [1:0]          phase_d;
	logic [TW-1:0]       timer_inc;
	logic [PERIOD_W:0]   cycle_len;
	logic [PERIOD_W:0]   on_prod;
	logic [PERIOD_W-1:0] on_time;
	logic [HALF_W-1:0]   half;
	logic [COUNT_W:0]    pc_inc;
	logic [COUNT_W:0]    pc_saw;
	logic [COUNT_W:0]    pc_tri;
	logic                pwm_on;
	logic                blink_on;
	logic                pwm_wrap;
	logic                blink_wrap;
	lpc_word_t           word_d;
	logic                accept;

	assign timer_inc = timer_q + TW'(1);
	assign cycle_len = (PERIOD_W+1)'(cfg.period) + (PERIOD_W+1)'(cfg.gap);
	assign on_prod   = (PERIOD_W+1)'(cfg.period_div) * (PERIOD_W+1)'(intensity_q);
	assign on_time   = (intensity_q < LEVEL_FULL) ? on_prod[PERIOD_W-1:0] : cfg.period;
	assign pwm_on    = CW'(timer_q) < CW'(on_time);
	assign pwm_wrap  = CW'(timer_inc) >= CW'(cycle_len);
	assign half      = (cfg.mode == MODE_FAST) ? cfg.fast_half : cfg.slow_half;
	assign blink_on  = (phase_q == PH_ON);
	assign blink_wrap = CW'(timer_inc) >= CW'(half);

	// period counter wraps at 100 (sawtooth) or 200 (triangle)
	assign pc_inc = (COUNT_W+1)'(pcount_q) + (COUNT_W+1)'(1);

	always_comb begin
		priority if (pc_inc >= TRI_WRAP) begin
			pc_saw = pc_inc - TRI_WRAP;
		end else if (pc_inc >= SAW_WRAP) begin
			pc_saw = pc_inc - SAW_WRAP;
		end else begin
			pc_saw = pc_inc;
		end
		pc_tri = (pc_inc >= TRI_WRAP) ? pc_inc - TRI_WRAP : pc_inc;
	end

	always_comb begin
		timer_d     = timer_q;
		pcount_d    = pcount_q;
		intensity_d = intensity_q;
		phase_d     = phase_q;
		word_d.fan_out = fan_on;
		word_d.lamp_on = 1'b0;
		word_d.level   = '0;
		case (cfg.mode)
			MODE_SAW, MODE_TRI: begin
				word_d.lamp_on = pwm_on;
				word_d.level   = intensity_q;
				phase_d = pwm_on ? PH_ON :
					((CW'(timer_q) < CW'(cfg.period)) ? PH_OFF : PH_GAP);
				if (pwm_wrap) begin
					timer_d = '0;
					if (cfg.mode == MODE_TRI) begin
						pcount_d    = pc_tri[COUNT_W-1:0];
						intensity_d = (pc_tri > (COUNT_W+1)'(LEVEL_FULL)) ?
							LEVEL_W'(TRI_WRAP - pc_tri) : pc_tri[LEVEL_W-1:0];
					end else begin
						pcount_d    = pc_saw[COUNT_W-1:0];
						intensity_d = pc_saw[LEVEL_W-1:0];
					end
				end else begin
					timer_d = timer_inc;
				end
			end
			MODE_FAST, MODE_SLOW: begin
				word_d.lamp_on = blink_on;
				if (blink_wrap) begin
					timer_d = '0;
					phase_d = blink_on ? PH_OFF : PH_ON;
				end else begin
					timer_d = timer_inc;
				end
			end
			default: begin
				// off and unknown modes: dark, counters hold
			end
		endcase
	end

	// two-entry output buffer
	lpc_word_t out_q;
	lpc_word_t skid_q;
	logic      out_vld_q;
	logic      skid_vld_q;
	logic      out_free;

	assign in_ready = !skid_vld_q;
	assign accept   = in_valid & in_ready;
	assign out_free = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q     <= '0;
			pcount_q    <= '0;
			intensity_q <= '0;
			phase_q     <= PH_ON;
		end else if (cfg.mode_wr) begin
			timer_q     <= '0;
			pcount_q    <= '0;
			intensity_q <= '0;
			phase_q     <= PH_ON;
		end else if (accept) begin
			timer_q     <= timer_d;
			pcount_q    <= pcount_d;
			intensity_q <= intensity_d;
			phase_q     <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= accept;
			end
		end else if (accept) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= word_d;
			end
		end else if (accept) begin
			skid_q <= word_d;
		end
	end

	assign out_valid = out_vld_q;
	assign lamp_on   = out_q.lamp_on;
	assign fan_out   = out_q.fan_out;
	assign level     = out_q.level;

endmodule

// File: rtl/lpc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the lamp PWM pattern controller, bound to the top level.
// Depends on lpc_pkg and lamp_pwm_pattern_controller.
module lpc_checker import lpc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               lamp_on,
	input logic               fan_out,
	input logic [LEVEL_W-1:0] level
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(lamp_on) && $stable(fan_out)
			&& $stable(level))
		else $error("stalled output word changed");

	// after an accepted word, a result word is valid on the next cycle
	a_acc_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word not presented");

	// input only backs up when a result is pending
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level <= LEVEL_FULL)
		else $error("level above full scale");

endmodule

bind lamp_pwm_pattern_controller lpc_checker u_lpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.lamp_on   (lamp_on),
	.fan_out   (fan_out),
	.level     (level)
);
